// ===== hw/rtl/mbp_pkg.sv =====
// Shared types and constants for the MIDI byte message parser.
// No dependencies; used by mbp_step, the top level and the checker.
`default_nettype none

package mbp_pkg;

    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
    localparam logic [2:0] KIND_NOTE_ON    = 3'd2;
    localparam logic [2:0] KIND_CONTROLLER = 3'd3;
    localparam logic [2:0] KIND_PROGRAM    = 3'd4;
    localparam logic [2:0] KIND_STRAY      = 3'd5;

    // upper nibbles of channel status bytes
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY_PRESS = 4'hA;
    localparam logic [3:0] ST_CONTROLLER = 4'hB;
    localparam logic [3:0] ST_PROGRAM    = 4'hC;
    localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
    localparam logic [3:0] ST_PITCH_BEND = 4'hE;

    // low nibbles of system status bytes
    localparam logic [3:0] SYS_SYSEX_START  = 4'h0;
    localparam logic [3:0] SYS_QUARTER_FRM  = 4'h1;
    localparam logic [3:0] SYS_SONG_POS     = 4'h2;
    localparam logic [3:0] SYS_SONG_SELECT  = 4'h3;

    localparam logic [7:0] SYSEX_END = 8'hF7;

    localparam int TDATA_W = 24;

    typedef struct packed {
        logic       in_sysex;
        logic [1:0] bytes_left;
        logic [2:0] pending_kind;
        logic [3:0] pending_channel;
        logic [7:0] first_data;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] channel;
        logic [7:0] param;
        logic [7:0] value;
    } midi_event_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbp_step.sv =====
// Combinational parse step: one MIDI byte against the current parser state.
// Depends on mbp_pkg for the state and event types and the status codes.
`default_nettype none

module mbp_step (
    input  wire logic [7:0]           midi_byte,
    input  wire mbp_pkg::parse_state_t state_cur,
    output mbp_pkg::parse_state_t      state_nxt,
    output logic                       emit,
    output mbp_pkg::midi_event_t       evt
);

    logic [3:0] upper;
    logic [3:0] lower;
    logic [1:0] len;
    logic [2:0] kind;
    logic       sysex_start;
    logic [1:0] left_dec;

    assign upper    = midi_byte[7:4];
    assign lower    = midi_byte[3:0];
    assign left_dec = state_cur.bytes_left - 2'd1;

    // status byte decode by standard message length
    always_comb begin
        len         = 2'd0;
        kind        = mbp_pkg::KIND_NONE;
        sysex_start = 1'b0;
        case (upper)
            mbp_pkg::ST_NOTE_OFF: begin
                kind = mbp_pkg::KIND_NOTE_OFF;
                len  = 2'd2;
            end
            mbp_pkg::ST_NOTE_ON: begin
                kind = mbp_pkg::KIND_NOTE_ON;
                len  = 2'd2;
            end
            mbp_pkg::ST_CONTROLLER: begin
                kind = mbp_pkg::KIND_CONTROLLER;
                len  = 2'd2;
            end
            mbp_pkg::ST_PROGRAM: begin
                kind = mbp_pkg::KIND_PROGRAM;
                len  = 2'd1;
            end
            mbp_pkg::ST_POLY_PRESS, mbp_pkg::ST_PITCH_BEND: begin
                len = 2'd2;
            end
            mbp_pkg::ST_CHAN_PRESS: begin
                len = 2'd1;
            end
            default: begin
                if (lower == mbp_pkg::SYS_SYSEX_START) begin
                    sysex_start = 1'b1;
                end else if (lower == mbp_pkg::SYS_QUARTER_FRM ||
                             lower == mbp_pkg::SYS_SONG_SELECT) begin
                    len = 2'd1;
                end else if (lower == mbp_pkg::SYS_SONG_POS) begin
                    len = 2'd2;
                end
            end
        endcase
    end

    always_comb begin
        state_nxt = state_cur;
        emit      = 1'b0;
        evt       = '0;
        if (state_cur.in_sysex) begin
            // swallow everything up to the end marker
            if (midi_byte == mbp_pkg::SYSEX_END) begin
                state_nxt.in_sysex = 1'b0;
            end
        end else if (state_cur.bytes_left != 2'd0) begin
            state_nxt.bytes_left = left_dec;
            if (left_dec != 2'd0) begin
                state_nxt.first_data = midi_byte;
            end else begin
                emit        = 1'b1;
                evt.channel = state_cur.pending_channel;
                case (state_cur.pending_kind)
                    mbp_pkg::KIND_NOTE_OFF, mbp_pkg::KIND_NOTE_ON,
                    mbp_pkg::KIND_CONTROLLER: begin
                        evt.event_kind = state_cur.pending_kind;
                        evt.param      = state_cur.first_data;
                        evt.value      = midi_byte;
                    end
                    mbp_pkg::KIND_PROGRAM: begin
                        evt.event_kind = state_cur.pending_kind;
                        evt.value      = midi_byte;
                    end
                    default: begin
                        evt.event_kind = mbp_pkg::KIND_NONE;
                    end
                endcase
            end
        end else if (!midi_byte[7]) begin
            emit           = 1'b1;
            evt.event_kind = mbp_pkg::KIND_STRAY;
            evt.channel    = lower;
        end else if (len == 2'd0) begin
            emit               = 1'b1;
            evt.event_kind     = mbp_pkg::KIND_NONE;
            evt.channel        = lower;
            state_nxt.in_sysex = sysex_start;
        end else begin
            state_nxt.pending_kind    = kind;
            state_nxt.pending_channel = lower;
            state_nxt.bytes_left      = len;
            state_nxt.first_data      = 8'd0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/midi_byte_message_parser.sv =====
// A byte taken into the input register goes through mbp_step; any event it makes shows on m_* from the result register.
// Throughput: one byte per cycle; the input register stalls only when its byte
// emits an event while the result register is held by m_tready low.
// Reset (aresetn low, synchronous) empties both registers and clears the
// parser state: no sysex, no pending message.
// Top level of the MIDI byte message parser; depends on mbp_pkg and mbp_step.
`default_nettype none

module midi_byte_message_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] midi_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] channel, [11:4] param, [19:12] value
    output logic [2:0]       m_tuser    // [2:0] event_kind
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    mbp_pkg::parse_state_t state_reg;
    mbp_pkg::parse_state_t state_next;
    logic                  out_valid_reg;
    mbp_pkg::midi_event_t  out_evt_reg;
    logic                  step_emit;
    mbp_pkg::midi_event_t  step_evt;
    logic                  out_free;
    logic                  step_go;

    mbp_step u_step (
        .midi_byte (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .evt       (step_evt)
    );

    assign out_free = !out_valid_reg || m_tready;
    // a byte with no result can always advance
    assign step_go  = in_valid_reg && (out_free || !step_emit);
    assign s_tready = !in_valid_reg || step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_go) begin
                state_reg <= state_next;
            end
            if (step_go && step_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (step_go && step_emit) begin
            out_evt_reg <= step_evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_evt_reg.event_kind;
    assign m_tdata  = {4'd0, out_evt_reg.value, out_evt_reg.param, out_evt_reg.channel};

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_checker.sv =====
// Port-level checks for midi_byte_message_parser, attached by bind.
// Depends on mbp_pkg for the event kind codes.
`default_nettype none

module mbp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mbp_pkg::KIND_NONE || m_tuser == mbp_pkg::KIND_STRAY)
        |-> m_tdata[23:4] == 20'd0)
        else $error("none or stray event carries param or value");

    a_program_param: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mbp_pkg::KIND_PROGRAM |-> m_tdata[11:4] == 8'd0)
        else $error("program change carries a param");

    a_stray_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mbp_pkg::KIND_STRAY && !$past(m_tvalid) |->
        $past(s_tvalid && s_tready, 2) && $past(!s_tdata[7], 2))
        else $error("stray event without a data byte two cycles before");

endmodule

bind midi_byte_message_parser mbp_checker u_mbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
